[rtl/core/tdcs_pkg.sv]
package tdcs_pkg;

  // event kinds carried in the input tuser
  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_VELOCITY  = 3'd1,
    ACT_FLIPPER   = 3'd2,
    ACT_POWER     = 3'd3,
    ACT_FLIP_MODE = 3'd4,
    ACT_DRIVE     = 3'd5
  } action_t;

  // configuration register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_TIMEOUT_TICKS    = 3'd0,
    REG_MAX_TRACK_RPM    = 3'd1,
    REG_ESTOP_VOLTAGE_MV = 3'd2,
    REG_POWERLESS_CODE   = 3'd3,
    REG_POWERED_CODE     = 3'd4
  } reg_idx_t;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // drive service codes and the control words they select
  localparam logic [1:0]  DRV_REFERENCE  = 2'd0;
  localparam logic [1:0]  DRV_RESET      = 2'd1;
  localparam logic [15:0] CTRL_REFERENCE = 16'b0000000000000001;
  localparam logic [15:0] CTRL_RESET     = 16'b1000000000000000;

  // reset values of the configuration registers
  localparam logic [7:0]  TIMEOUT_TICKS_RST    = 8'd10;
  localparam logic [14:0] MAX_TRACK_RPM_RST    = 15'd16000;
  localparam logic [15:0] ESTOP_VOLTAGE_MV_RST = 16'd20000;
  localparam logic [15:0] POWERLESS_CODE_RST   = 16'd2;
  localparam logic [15:0] POWERED_CODE_RST     = 16'd0;

  localparam logic [7:0] AGE_MAX = 8'hff;

  // side speed in um/s: 1000*lin +/- 180*ang (half track spacing 0.18 m)
  localparam int SPEED_W = 24;
  localparam logic signed [SPEED_W-1:0] LIN_SCALE = 24'sd1000;
  localparam logic signed [SPEED_W-1:0] ANG_SCALE = 24'sd180;

  // rpm per um/s in Q32: 60*180/(0.159*pi) / 1e6
  localparam int RPM_K_W = 27;
  localparam logic [RPM_K_W-1:0] RPM_K_Q32 = 27'd92861698;
  localparam int RPM_PROD_W = SPEED_W - 1 + RPM_K_W;

  // encoder ticks per mrad in Q16: 6.75*216*512/(2000*pi)
  localparam int TICK_K_W = 23;
  localparam logic [TICK_K_W-1:0] TICK_K_Q16 = 23'd7786236;
  localparam int TICK_PROD_W = 14 + TICK_K_W;
  localparam logic [TICK_PROD_W-1:0] TICK_HALF = 37'd32768;

  typedef struct packed {
    logic [1:0]         drive_command;
    logic               flag_on;
    logic [15:0]        battery_mv;
    logic signed [13:0] angle_rear_right;
    logic signed [13:0] angle_rear_left;
    logic signed [13:0] angle_front_right;
    logic signed [13:0] angle_front_left;
    logic signed [13:0] ang_vel_mrad_s;
    logic signed [12:0] lin_vel_mm_s;
  } in_data_t;

  typedef struct packed {
    logic               accepted;
    logic               estop_active;
    logic [15:0]        control_word;
    logic signed [20:0] ticks_rear_right;
    logic signed [20:0] ticks_rear_left;
    logic signed [20:0] ticks_front_right;
    logic signed [20:0] ticks_front_left;
    logic signed [15:0] track_right_rpm;
    logic signed [15:0] track_left_rpm;
  } out_data_t;

  localparam int IN_DATA_W  = $bits(in_data_t);
  localparam int OUT_DATA_W = $bits(out_data_t);
  localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

  // side speed to track rpm, truncated toward zero and clamped to lim
  function automatic logic signed [15:0] speed_to_rpm(
    input logic signed [SPEED_W-1:0] v,
    input logic [14:0]               lim
  );
    logic [SPEED_W-2:0]    mag;
    logic [RPM_PROD_W-1:0] prod;
    logic [RPM_PROD_W-33:0] rpm;
    logic [14:0]           sat;
    logic signed [15:0]    pos;
    mag  = v[SPEED_W-1] ? (SPEED_W-1)'(-v) : (SPEED_W-1)'(v);
    prod = RPM_PROD_W'(mag) * RPM_PROD_W'(RPM_K_Q32);
    rpm  = prod[RPM_PROD_W-1:32];
    sat  = (rpm > (RPM_PROD_W-32)'(lim)) ? lim : rpm[14:0];
    pos  = $signed({1'b0, sat});
    return v[SPEED_W-1] ? -pos : pos;
  endfunction

  // flipper angle to encoder ticks, rounded half away from zero
  function automatic logic signed [20:0] angle_to_ticks(input logic signed [13:0] a);
    logic [13:0]            mag;
    logic [TICK_PROD_W-1:0] prod;
    logic signed [20:0]     pos;
    mag  = a[13] ? 14'(-a) : 14'(a);
    prod = TICK_PROD_W'(mag) * TICK_PROD_W'(TICK_K_Q16) + TICK_HALF;
    pos  = $signed(prod[36:16]);
    return a[13] ? -pos : pos;
  endfunction

endpackage

[rtl/core/track_drive_command_supervisor_unit.sv]
// Motor command supervisor for a tracked robot. Every input transaction is one event,
// chosen by in_tuser: tick, velocity, flipper angles, power report, flipper power mode
// or drive command. Each event answers with exactly one output transaction carrying the
// current motor frame (track rpm, flipper ticks, control word, estop) plus frame_valid
// in out_tuser, which is high only on ticks. The block takes one transaction per clock
// unless a held result stalls it; items pass the input register, then the result register,
// and state updates between them, so back-to-back events see each other's effects.
// Velocity and flipper scaling are constant multiplies done between the two registers.
// The user must write configuration over APB only while idle; the block does not check.
module track_drive_command_supervisor_unit
  import tdcs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // lin_vel_mm_s, ang_vel_mrad_s, angle_front_left, angle_front_right,
  // angle_rear_left, angle_rear_right, battery_mv, flag_on, drive_command
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action
  input  logic [2:0]             in_tuser,

  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // track_left_rpm, track_right_rpm, ticks_front_left, ticks_front_right,
  // ticks_rear_left, ticks_rear_right, control_word, estop_active, accepted
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // frame_valid
  output logic                   out_tuser,

  // configuration port
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  // configuration registers
  logic [7:0]  timeout_ticks_r;
  logic [14:0] max_track_rpm_r;
  logic [15:0] estop_voltage_mv_r;
  logic [15:0] powerless_code_r;
  logic [15:0] powered_code_r;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_ticks_r    <= TIMEOUT_TICKS_RST;
      max_track_rpm_r    <= MAX_TRACK_RPM_RST;
      estop_voltage_mv_r <= ESTOP_VOLTAGE_MV_RST;
      powerless_code_r   <= POWERLESS_CODE_RST;
      powered_code_r     <= POWERED_CODE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TIMEOUT_TICKS:    timeout_ticks_r    <= cfg_pwdata[7:0];
        REG_MAX_TRACK_RPM:    max_track_rpm_r    <= cfg_pwdata[14:0];
        REG_ESTOP_VOLTAGE_MV: estop_voltage_mv_r <= cfg_pwdata[15:0];
        REG_POWERLESS_CODE:   powerless_code_r   <= cfg_pwdata[15:0];
        REG_POWERED_CODE:     powered_code_r     <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TIMEOUT_TICKS:    cfg_prdata = CFG_DATA_W'(timeout_ticks_r);
      REG_MAX_TRACK_RPM:    cfg_prdata = CFG_DATA_W'(max_track_rpm_r);
      REG_ESTOP_VOLTAGE_MV: cfg_prdata = CFG_DATA_W'(estop_voltage_mv_r);
      REG_POWERLESS_CODE:   cfg_prdata = CFG_DATA_W'(powerless_code_r);
      REG_POWERED_CODE:     cfg_prdata = CFG_DATA_W'(powered_code_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // input register and stall control
  logic     in_valid_r;
  in_data_t in_item_r;
  action_t  in_action_r;
  logic     out_valid_r;
  logic     advance;
  logic     fire;

  // result register frees up when empty or being taken this cycle
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign fire      = in_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r   <= in_data_t'(in_tdata[IN_DATA_W-1:0]);
      in_action_r <= action_t'(in_tuser);
    end
  end

  // supervisor state
  logic [7:0]         command_age_r,   command_age_nxt;
  logic [7:0]         power_age_r,     power_age_nxt;
  logic [15:0]        battery_level_r, battery_level_nxt;
  logic               estop_r,         estop_nxt;
  logic signed [15:0] track_left_r,    track_left_nxt;
  logic signed [15:0] track_right_r,   track_right_nxt;
  logic signed [20:0] flipper_r   [4];
  logic signed [20:0] flipper_nxt [4];
  logic [15:0]        control_value_r, control_value_nxt;
  logic               oneshot_r,       oneshot_nxt;

  // velocity and flipper datapath
  logic signed [SPEED_W-1:0] lin_um, ang_um, v_left, v_right;
  logic signed [15:0]        rpm_left, rpm_right;
  logic signed [20:0]        ticks_new [4];

  assign lin_um    = SPEED_W'(in_item_r.lin_vel_mm_s) * LIN_SCALE;
  assign ang_um    = SPEED_W'(in_item_r.ang_vel_mrad_s) * ANG_SCALE;
  assign v_left    = lin_um - ang_um;
  assign v_right   = lin_um + ang_um;
  assign rpm_left  = speed_to_rpm(v_left, max_track_rpm_r);
  assign rpm_right = speed_to_rpm(v_right, max_track_rpm_r);

  assign ticks_new[0] = angle_to_ticks(in_item_r.angle_front_left);
  assign ticks_new[1] = angle_to_ticks(in_item_r.angle_front_right);
  assign ticks_new[2] = angle_to_ticks(in_item_r.angle_rear_left);
  assign ticks_new[3] = angle_to_ticks(in_item_r.angle_rear_right);

  // tick watchdog terms
  logic [7:0] cmd_age_inc, pwr_age_inc;
  logic       timed_out, low_battery;

  assign cmd_age_inc = (command_age_r == AGE_MAX) ? command_age_r : command_age_r + 8'd1;
  assign pwr_age_inc = (power_age_r == AGE_MAX) ? power_age_r : power_age_r + 8'd1;
  assign timed_out   = (cmd_age_inc > timeout_ticks_r) || (pwr_age_inc > timeout_ticks_r);
  assign low_battery = battery_level_r < estop_voltage_mv_r;

  logic [15:0] ctrl_out;
  logic        frame_out;
  logic        accepted_out;

  always_comb begin
    command_age_nxt   = command_age_r;
    power_age_nxt     = power_age_r;
    battery_level_nxt = battery_level_r;
    estop_nxt         = estop_r;
    track_left_nxt    = track_left_r;
    track_right_nxt   = track_right_r;
    flipper_nxt       = flipper_r;
    control_value_nxt = control_value_r;
    oneshot_nxt       = oneshot_r;
    frame_out         = 1'b0;
    accepted_out      = 1'b0;
    ctrl_out          = control_value_r;

    unique case (in_action_r)
      ACT_TICK: begin
        command_age_nxt = cmd_age_inc;
        power_age_nxt   = pwr_age_inc;
        estop_nxt       = low_battery;
        if (timed_out || low_battery) begin
          track_left_nxt  = '0;
          track_right_nxt = '0;
        end
        frame_out = 1'b1;
        // one-shot drive word goes out once in this frame, then clears
        if (oneshot_r) begin
          control_value_nxt = '0;
          oneshot_nxt       = 1'b0;
        end
      end
      ACT_VELOCITY: begin
        track_left_nxt  = rpm_left;
        track_right_nxt = rpm_right;
        command_age_nxt = '0;
      end
      ACT_FLIPPER: begin
        if (!estop_r) begin
          flipper_nxt = ticks_new;
        end
      end
      ACT_POWER: begin
        battery_level_nxt = in_item_r.battery_mv;
        power_age_nxt     = '0;
      end
      ACT_FLIP_MODE: begin
        accepted_out      = in_item_r.flag_on;
        control_value_nxt = in_item_r.flag_on ? powerless_code_r : powered_code_r;
        ctrl_out          = control_value_nxt;
      end
      ACT_DRIVE: begin
        if (in_item_r.drive_command == DRV_REFERENCE ||
            in_item_r.drive_command == DRV_RESET) begin
          control_value_nxt = (in_item_r.drive_command == DRV_REFERENCE) ?
                              CTRL_REFERENCE : CTRL_RESET;
          oneshot_nxt       = 1'b1;
          accepted_out      = 1'b1;
          ctrl_out          = control_value_nxt;
        end
      end
      default: ;  // unused event codes only report the state
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      command_age_r   <= '0;
      power_age_r     <= '0;
      battery_level_r <= '0;
      estop_r         <= 1'b1;
      track_left_r    <= '0;
      track_right_r   <= '0;
      for (int i = 0; i < 4; i++) begin
        flipper_r[i] <= '0;
      end
      control_value_r <= '0;
      oneshot_r       <= 1'b0;
    end else if (fire) begin
      command_age_r   <= command_age_nxt;
      power_age_r     <= power_age_nxt;
      battery_level_r <= battery_level_nxt;
      estop_r         <= estop_nxt;
      track_left_r    <= track_left_nxt;
      track_right_r   <= track_right_nxt;
      flipper_r       <= flipper_nxt;
      control_value_r <= control_value_nxt;
      oneshot_r       <= oneshot_nxt;
    end
  end

  // result register
  out_data_t out_item_r;
  logic      frame_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r.track_left_rpm    <= track_left_nxt;
      out_item_r.track_right_rpm   <= track_right_nxt;
      out_item_r.ticks_front_left  <= flipper_nxt[0];
      out_item_r.ticks_front_right <= flipper_nxt[1];
      out_item_r.ticks_rear_left   <= flipper_nxt[2];
      out_item_r.ticks_rear_right  <= flipper_nxt[3];
      out_item_r.control_word      <= ctrl_out;
      out_item_r.estop_active      <= estop_nxt;
      out_item_r.accepted          <= accepted_out;
      frame_valid_r                <= frame_out;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_item_r);
  assign out_tuser  = frame_valid_r;

endmodule

[bench/tdcs_frame_checker.sv]
`timescale 1ns / 100ps

module tdcs_frame_checker
  import tdcs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [2:0]             in_tuser,

  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tuser,

  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  input  logic                   cfg_pready,

  output int                     mismatches,
  output int                     in_flight
);

  // rpm per um/s in Q32, encoder ticks per mrad in Q16
  localparam longint UMS_TO_RPM_Q32    = 92861698;
  localparam longint MRAD_TO_TICKS_Q16 = 7786236;
  localparam longint Q16_HALF          = 32768;
  localparam longint UM_PER_MM         = 1000;
  localparam longint HALF_TRACK_MM     = 180;
  localparam logic [7:0] AGE_CEIL      = 8'hff;

  typedef struct packed {
    out_data_t data;
    logic      frame_valid;
  } frame_t;

  // register mirror
  logic [7:0]  lim_timeout;
  logic [14:0] lim_rpm;
  logic [15:0] estop_mv;
  logic [15:0] code_unpowered;
  logic [15:0] code_powered;

  // supervisor state
  logic [7:0]         cmd_age;
  logic [7:0]         pwr_age;
  logic [15:0]        battery;
  logic               estop;
  logic signed [15:0] rpm_left;
  logic signed [15:0] rpm_right;
  logic signed [20:0] flip_ticks [4];
  logic [15:0]        ctrl;
  logic               ctrl_oneshot;

  frame_t frames_due [$];

  function automatic logic signed [15:0] side_rpm(input longint v_um);
    longint mag;
    longint r;
    mag = (v_um < 0) ? -v_um : v_um;
    r   = (mag * UMS_TO_RPM_Q32) >> 32;
    if (r > longint'(lim_rpm)) r = longint'(lim_rpm);
    return 16'((v_um < 0) ? -r : r);
  endfunction

  function automatic logic signed [20:0] flip_to_ticks(input longint a);
    longint mag;
    longint t;
    mag = (a < 0) ? -a : a;
    t   = (mag * MRAD_TO_TICKS_Q16 + Q16_HALF) >> 16;
    return 21'((a < 0) ? -t : t);
  endfunction

  // one event through the supervisor; the one-shot clear lands after the frame
  task automatic step_supervisor(input logic [2:0] act, input in_data_t d, output frame_t f);
    logic   acc;
    logic   clear_ctrl;
    longint lin;
    longint ang;
    acc        = 1'b0;
    clear_ctrl = 1'b0;
    f          = '0;
    lin        = $signed(d.lin_vel_mm_s);
    ang        = $signed(d.ang_vel_mrad_s);
    case (act)
      ACT_TICK: begin
        if (cmd_age != AGE_CEIL) cmd_age = cmd_age + 8'd1;
        if (pwr_age != AGE_CEIL) pwr_age = pwr_age + 8'd1;
        if (cmd_age > lim_timeout || pwr_age > lim_timeout) begin
          rpm_left  = '0;
          rpm_right = '0;
        end
        estop = battery < estop_mv;
        if (estop) begin
          rpm_left  = '0;
          rpm_right = '0;
        end
        f.frame_valid = 1'b1;
        clear_ctrl    = ctrl_oneshot;
      end
      ACT_VELOCITY: begin
        rpm_left  = side_rpm(lin * UM_PER_MM - ang * HALF_TRACK_MM);
        rpm_right = side_rpm(lin * UM_PER_MM + ang * HALF_TRACK_MM);
        cmd_age   = '0;
      end
      ACT_FLIPPER: begin
        if (!estop) begin
          flip_ticks[0] = flip_to_ticks($signed(d.angle_front_left));
          flip_ticks[1] = flip_to_ticks($signed(d.angle_front_right));
          flip_ticks[2] = flip_to_ticks($signed(d.angle_rear_left));
          flip_ticks[3] = flip_to_ticks($signed(d.angle_rear_right));
        end
      end
      ACT_POWER: begin
        battery = d.battery_mv;
        pwr_age = '0;
      end
      ACT_FLIP_MODE: begin
        acc  = d.flag_on;
        ctrl = d.flag_on ? code_unpowered : code_powered;
      end
      ACT_DRIVE: begin
        if (d.drive_command == DRV_REFERENCE || d.drive_command == DRV_RESET) begin
          ctrl         = (d.drive_command == DRV_REFERENCE) ? CTRL_REFERENCE : CTRL_RESET;
          ctrl_oneshot = 1'b1;
          acc          = 1'b1;
        end
      end
      default: ;
    endcase
    f.data.track_left_rpm    = rpm_left;
    f.data.track_right_rpm   = rpm_right;
    f.data.ticks_front_left  = flip_ticks[0];
    f.data.ticks_front_right = flip_ticks[1];
    f.data.ticks_rear_left   = flip_ticks[2];
    f.data.ticks_rear_right  = flip_ticks[3];
    f.data.control_word      = ctrl;
    f.data.estop_active      = estop;
    f.data.accepted          = acc;
    if (clear_ctrl) begin
      ctrl         = '0;
      ctrl_oneshot = 1'b0;
    end
  endtask

  function automatic void check_field(input string name, input longint want, input longint seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    frame_t    want;
    frame_t    fresh;
    out_data_t seen;
    if (!rst_n) begin
      lim_timeout    = TIMEOUT_TICKS_RST;
      lim_rpm        = MAX_TRACK_RPM_RST;
      estop_mv       = ESTOP_VOLTAGE_MV_RST;
      code_unpowered = POWERLESS_CODE_RST;
      code_powered   = POWERED_CODE_RST;
      cmd_age        = '0;
      pwr_age        = '0;
      battery        = '0;
      estop          = 1'b1;
      rpm_left       = '0;
      rpm_right      = '0;
      for (int i = 0; i < 4; i++) flip_ticks[i] = '0;
      ctrl           = '0;
      ctrl_oneshot   = 1'b0;
      frames_due.delete();
      mismatches     = 0;
      in_flight     <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]))
          REG_TIMEOUT_TICKS:    lim_timeout    = cfg_pwdata[7:0];
          REG_MAX_TRACK_RPM:    lim_rpm        = cfg_pwdata[14:0];
          REG_ESTOP_VOLTAGE_MV: estop_mv       = cfg_pwdata[15:0];
          REG_POWERLESS_CODE:   code_unpowered = cfg_pwdata[15:0];
          REG_POWERED_CODE:     code_powered   = cfg_pwdata[15:0];
          default: ;
        endcase
      end

      // results first so a stray one is never matched against a fresh event
      if (out_tvalid && out_tready) begin
        seen = out_tdata[OUT_DATA_W-1:0];
        if (frames_due.size() == 0) begin
          $error("unexpected output transaction");
          mismatches++;
        end else begin
          want = frames_due.pop_front();
          check_field("track_left_rpm", want.data.track_left_rpm, seen.track_left_rpm);
          check_field("track_right_rpm", want.data.track_right_rpm, seen.track_right_rpm);
          check_field("ticks_front_left", want.data.ticks_front_left, seen.ticks_front_left);
          check_field("ticks_front_right", want.data.ticks_front_right,
                      seen.ticks_front_right);
          check_field("ticks_rear_left", want.data.ticks_rear_left, seen.ticks_rear_left);
          check_field("ticks_rear_right", want.data.ticks_rear_right, seen.ticks_rear_right);
          check_field("control_word", want.data.control_word, seen.control_word);
          check_field("estop_active", want.data.estop_active, seen.estop_active);
          check_field("frame_valid", want.frame_valid, out_tuser);
          check_field("accepted", want.data.accepted, seen.accepted);
        end
      end

      if (in_tvalid && in_tready) begin
        step_supervisor(in_tuser, in_tdata[IN_DATA_W-1:0], fresh);
        frames_due.push_back(fresh);
      end

      in_flight <= frames_due.size();
    end
  end

endmodule

[bench/tb_track_drive_command_supervisor_unit.sv]
`timescale 1ns / 100ps

module tb_track_drive_command_supervisor_unit
  import tdcs_pkg::*;
();

  // tuser codes the block has no event for, and drive codes it must reject
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;
  localparam logic [1:0] DRV_BAD_LO  = 2'd2;
  localparam logic [1:0] DRV_BAD_HI  = 2'd3;

  // kinds of register setting
  localparam int SET_ALL_LOW  = 0;
  localparam int SET_ALL_HIGH = 1;
  localparam int SET_RANDOM   = 2;

  localparam int SEGMENTS      = 6;
  localparam int SEGMENT_ITEMS = 130;
  localparam int SOAK_TICKS    = 262;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  // lin_vel_mm_s, ang_vel_mrad_s, angle_front_left, angle_front_right,
  // angle_rear_left, angle_rear_right, battery_mv, flag_on, drive_command
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  // action
  logic [2:0]             in_tuser    = '0;

  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  // track_left_rpm, track_right_rpm, ticks_front_left, ticks_front_right,
  // ticks_rear_left, ticks_rear_right, control_word, estop_active, accepted
  logic [OUT_TDATA_W-1:0] out_tdata;
  // frame_valid
  logic                   out_tuser;

  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  int mismatches;
  int in_flight;

  // percentage of cycles each side holds back
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  // current estop threshold, so battery reports can land close to it
  int cur_estop_mv = int'(ESTOP_VOLTAGE_MV_RST);

  track_drive_command_supervisor_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // watches both streams and the register port, predicts every frame
  tdcs_frame_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .in_flight   (in_flight)
  );

  always #1 clk = ~clk;

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // hard stop if the block hangs
  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  // random content for every field, so unused fields toggle too
  function automatic in_data_t noise_payload();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return r[IN_DATA_W-1:0];
  endfunction

  // register write: setup phase, access phase, then the bus goes idle
  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(idx) << 2;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid and let every outstanding frame come back before touching registers
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apply_setting(input int kind);
    logic [7:0]  timeout;
    logic [14:0] rpm_lim;
    logic [15:0] estop_lvl;
    logic [15:0] unpowered;
    logic [15:0] powered;
    case (kind)
      SET_ALL_LOW: begin
        // every tick times out, tracks clamp to zero, estop can never hold
        timeout   = '0;
        rpm_lim   = '0;
        estop_lvl = '0;
        unpowered = 16'hffff;
        powered   = '0;
      end
      SET_ALL_HIGH: begin
        // watchdog never fires, rpm limit wide open, estop unless battery is full
        timeout   = 8'hff;
        rpm_lim   = 15'h7fff;
        estop_lvl = 16'hffff;
        unpowered = '0;
        powered   = 16'hffff;
      end
      default: begin
        timeout   = 8'($urandom_range(12));
        rpm_lim   = 15'($urandom_range(32767));
        estop_lvl = 16'($urandom_range(65535));
        unpowered = 16'($urandom);
        powered   = 16'($urandom);
      end
    endcase
    cfg_write(REG_TIMEOUT_TICKS, CFG_DATA_W'(timeout));
    cfg_write(REG_MAX_TRACK_RPM, CFG_DATA_W'(rpm_lim));
    cfg_write(REG_ESTOP_VOLTAGE_MV, CFG_DATA_W'(estop_lvl));
    cfg_write(REG_POWERLESS_CODE, CFG_DATA_W'(unpowered));
    cfg_write(REG_POWERED_CODE, CFG_DATA_W'(powered));
    cur_estop_mv = int'(estop_lvl);
  endtask

  // one input transaction; valid stays up until the block takes it
  task automatic send_event(input logic [2:0] act, input in_data_t d);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= IN_TDATA_W'(d);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_velocity(input logic signed [12:0] lin, input logic signed [13:0] ang);
    in_data_t d;
    d                = noise_payload();
    d.lin_vel_mm_s   = lin;
    d.ang_vel_mrad_s = ang;
    send_event(ACT_VELOCITY, d);
  endtask

  task automatic send_flippers(input logic signed [13:0] fl, input logic signed [13:0] fr,
                               input logic signed [13:0] rl, input logic signed [13:0] rr);
    in_data_t d;
    d                   = noise_payload();
    d.angle_front_left  = fl;
    d.angle_front_right = fr;
    d.angle_rear_left   = rl;
    d.angle_rear_right  = rr;
    send_event(ACT_FLIPPER, d);
  endtask

  task automatic send_power(input logic [15:0] mv);
    in_data_t d;
    d            = noise_payload();
    d.battery_mv = mv;
    send_event(ACT_POWER, d);
  endtask

  task automatic send_mode(input logic flag);
    in_data_t d;
    d         = noise_payload();
    d.flag_on = flag;
    send_event(ACT_FLIP_MODE, d);
  endtask

  task automatic send_drive(input logic [1:0] code);
    in_data_t d;
    d               = noise_payload();
    d.drive_command = code;
    send_event(ACT_DRIVE, d);
  endtask

  // weighted event mix: ticks dominate so watchdogs, estop and one-shots all cycle
  task automatic random_event();
    int unsigned pick;
    int          mv;
    pick = $urandom_range(99);
    if (pick < 30) begin
      send_event(ACT_TICK, noise_payload());
    end else if (pick < 50) begin
      // half of the commands small enough to stay under the rpm clamp
      if ($urandom_range(1)) begin
        send_velocity(13'($urandom_range(1400) - 700), 14'($urandom_range(4000) - 2000));
      end else begin
        send_velocity(13'($urandom), 14'($urandom));
      end
    end else if (pick < 65) begin
      send_flippers(14'($urandom), 14'($urandom), 14'($urandom), 14'($urandom));
    end else if (pick < 77) begin
      // battery half the time right around the threshold to flip estop both ways
      case ($urandom_range(9))
        0:       mv = 0;
        1:       mv = 65535;
        2, 3, 4: mv = $urandom_range(65535);
        default: mv = cur_estop_mv + int'($urandom_range(4)) - 2;
      endcase
      if (mv < 0) mv = 0;
      if (mv > 65535) mv = 65535;
      send_power(16'(mv));
    end else if (pick < 85) begin
      send_mode(1'($urandom_range(1)));
    end else if (pick < 95) begin
      send_drive(2'($urandom_range(3)));
    end else begin
      send_event($urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B, noise_payload());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset register values
    send_event(ACT_TICK, noise_payload());        // battery still zero: estop holds
    send_flippers(-8192, 8191, -6283, 6283);      // ignored while estop holds
    send_power(16'hffff);
    send_event(ACT_TICK, noise_payload());        // estop released
    send_flippers(-8192, 8191, -1, 1);            // extremes and rounding near zero
    send_flippers(0, -6283, 6283, 2);
    send_velocity(4095, 0);                       // clamps to the rpm limit
    send_velocity(-4096, -8192);
    send_velocity(0, 8191);                       // pure turn, sides opposite
    send_velocity(1, -1);                         // truncates toward zero
    send_event(ACT_TICK, noise_payload());
    send_mode(1'b1);
    send_mode(1'b0);
    send_drive(DRV_REFERENCE);
    send_event(ACT_TICK, noise_payload());        // one-shot goes out, then clears
    send_drive(DRV_RESET);
    send_mode(1'b1);                              // one-shot stays pending
    send_event(ACT_TICK, noise_payload());
    send_drive(DRV_BAD_LO);
    send_drive(DRV_BAD_HI);
    send_event(ACT_SPARE_A, noise_payload());
    send_event(ACT_SPARE_B, noise_payload());
    send_power(16'd19999);                        // one below the threshold
    send_event(ACT_TICK, noise_payload());        // estop back on
    send_power(16'd20000);

    // random part: idle pattern moves every two segments, registers every segment
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      case (seg / 2)
        0: begin
          tx_idle_pct = 22;
          rx_idle_pct = 71;
        end
        1: begin
          tx_idle_pct = 71;
          rx_idle_pct = 22;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (seg)
        1:       apply_setting(SET_ALL_LOW);
        3:       apply_setting(SET_ALL_HIGH);
        default: apply_setting(SET_RANDOM);
      endcase
      if (seg == 3) begin
        // both ages run into saturation with the watchdog at its top value
        send_power(16'hffff);
        send_velocity(2000, 300);
        repeat (SOAK_TICKS) send_event(ACT_TICK, noise_payload());
      end
      repeat (SEGMENT_ITEMS) random_event();
    end

    wait_idle();
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
